[rtl/c2d_pkg.sv]
package c2d_pkg;

   // input beat: one pixel in raster order
   typedef struct packed {
      logic [7:0] pixel;
      logic       frame_start;
   } req_type;

   // result beat: filtered value at one interior position
   typedef struct packed {
      logic signed [27:0] filtered_value;
      logic [11:0]        center_col;
      logic [11:0]        center_row;
   } rsp_type;

   // full 3x3 window handed from front to back, index row*3 + column
   typedef struct packed {
      logic [8:0][7:0] px;
      logic [11:0]     center_col;
      logic [11:0]     center_row;
   } win_type;

   // register indexes of the CSR port
   typedef enum logic [1:0] {
      CSR_IMAGE_WIDTH = 2'd0,
      CSR_COEF_TOP    = 2'd1,
      CSR_COEF_MID    = 2'd2,
      CSR_COEF_BOTTOM = 2'd3
   } csr_index_type;

   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_W    = 2;
   localparam int Q_CNT_W    = 3;
   localparam int OUT_DEPTH  = 4;
   localparam int OUT_PTR_W  = 2;
   localparam int OUT_CNT_W  = 3;

   localparam logic [12:0] WIDTH_RESET = 13'd640;
   localparam logic [47:0] COEF_TOP_RESET = 48'd0;
   localparam logic [47:0] COEF_MID_RESET = 48'd256;
   localparam logic [47:0] COEF_BOTTOM_RESET = 48'd0;

endpackage

[rtl/c2d_front.sv]
module c2d_front #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  c2d_pkg::req_type                  req_data,
   input  logic [12:0]                       image_width,
   input  logic [c2d_pkg::Q_CNT_W-1:0]       q_count,
   output logic                              q_push,
   output c2d_pkg::win_type                  q_data
);
   import c2d_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WID_W = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W = $clog2(MAX_HEIGHT);

   logic [7:0] older_mem [MAX_WIDTH];
   logic [7:0] newer_mem [MAX_WIDTH];

   logic [COL_W-1:0] col_ff, col_in, col_cur;
   logic [ROW_W-1:0] row_ff, row_in, row_cur;
   logic             accept;
   logic             emit_cur;
   logic             last_col;
   logic [WID_W-1:0] eff_width;

   // stage 1 registers
   logic             s1_valid_ff;
   logic             s1_emit_ff;
   logic [7:0]       s1_px_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic [7:0]       older_rd_ff, newer_rd_ff;
   logic             fwd_ff;
   logic [7:0]       fwd_older_ff, fwd_newer_ff;
   logic [7:0]       s1_top, s1_mid;
   logic             fwd_hit;

   logic [5:0][7:0]  win_ff;

   logic [Q_CNT_W:0] q_used;

   // hold off when the queue could not take an item already in flight
   assign q_used = {1'b0, q_count} + (Q_CNT_W + 1)'(s1_valid_ff & s1_emit_ff);
   assign req_full = (q_used >= (Q_CNT_W + 1)'(Q_DEPTH));
   assign accept = req_push & ~req_full;

   // effective width, clamped to 3..MAX_WIDTH
   always_comb begin
      if (image_width < 13'd3) begin
         eff_width = WID_W'(3);
      end else if (int'(image_width) > MAX_WIDTH) begin
         eff_width = WID_W'(MAX_WIDTH);
      end else begin
         eff_width = WID_W'(image_width);
      end
   end

   // position of the arriving pixel and next position
   always_comb begin
      col_cur  = req_data.frame_start ? '0 : col_ff;
      row_cur  = req_data.frame_start ? '0 : row_ff;
      emit_cur = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
      last_col = (WID_W'(col_cur) + WID_W'(1)) >= eff_width;
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            if (int'(row_cur) < MAX_HEIGHT - 1) begin
               row_in = row_cur + ROW_W'(1);
            end else begin
               row_in = row_cur;
            end
         end else begin
            col_in = col_cur + COL_W'(1);
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
      end
   end

   // read in the same cycle as a write to that entry: take the write data
   assign fwd_hit = s1_valid_ff && (s1_col_ff == col_cur);
   assign s1_top  = fwd_ff ? fwd_older_ff : older_rd_ff;
   assign s1_mid  = fwd_ff ? fwd_newer_ff : newer_rd_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff   <= emit_cur;
         s1_px_ff     <= req_data.pixel;
         s1_col_ff    <= col_cur;
         s1_row_ff    <= row_cur;
         fwd_ff       <= fwd_hit;
         fwd_older_ff <= s1_mid;
         fwd_newer_ff <= s1_px_ff;
      end
   end

   // line buffers: read at acceptance, written in the following cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         older_rd_ff <= older_mem[col_cur];
      end
      if (s1_valid_ff) begin
         older_mem[s1_col_ff] <= s1_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         newer_rd_ff <= newer_mem[col_cur];
      end
      if (s1_valid_ff) begin
         newer_mem[s1_col_ff] <= s1_px_ff;
      end
   end

   // window shift: two previous columns
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (s1_valid_ff) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= s1_top;
         win_ff[4] <= s1_mid;
         win_ff[5] <= s1_px_ff;
      end
   end

   // window beat to the back end
   always_comb begin
      q_push           = s1_valid_ff & s1_emit_ff;
      q_data.px[0]     = win_ff[0];
      q_data.px[1]     = win_ff[3];
      q_data.px[2]     = s1_top;
      q_data.px[3]     = win_ff[1];
      q_data.px[4]     = win_ff[4];
      q_data.px[5]     = s1_mid;
      q_data.px[6]     = win_ff[2];
      q_data.px[7]     = win_ff[5];
      q_data.px[8]     = s1_px_ff;
      q_data.center_col = 12'(s1_col_ff - COL_W'(1));
      q_data.center_row = 12'(s1_row_ff - ROW_W'(1));
   end

endmodule

[rtl/c2d_queue.sv]
module c2d_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  c2d_pkg::win_type            push_data,
   input  logic                        pop,
   output logic                        empty,
   output c2d_pkg::win_type            head,
   output logic [c2d_pkg::Q_CNT_W-1:0] count
);
   import c2d_pkg::*;

   win_type              entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [Q_CNT_W-1:0]   count_ff;
   logic                 do_push, do_pop;

   // front end never pushes into a full queue
   assign do_push = push;
   assign do_pop  = pop & (count_ff != '0);
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign count   = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + Q_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + Q_PTR_W'(1);
         end
         count_ff <= count_ff + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/c2d_back.sv]
module c2d_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  c2d_pkg::win_type      q_head,
   output logic                  q_pop,
   input  logic [47:0]           coef_row_top,
   input  logic [47:0]           coef_row_mid,
   input  logic [47:0]           coef_row_bottom,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output c2d_pkg::rsp_type      rsp_data
);
   import c2d_pkg::*;

   logic [2:0][47:0]    coef_rows;
   logic signed [24:0]  prod_in  [9];
   logic signed [24:0]  a_prod_ff [9];
   logic                a_valid_ff;
   logic [11:0]         a_col_ff, a_row_ff;
   logic signed [26:0]  b_sum_ff [3];
   logic                b_valid_ff;
   logic [11:0]         b_col_ff, b_row_ff;
   rsp_type             result;

   rsp_type             out_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [OUT_CNT_W-1:0] count_ff;
   logic [OUT_CNT_W:0]   out_used;
   logic                 do_pop;

   assign coef_rows[0] = coef_row_top;
   assign coef_rows[1] = coef_row_mid;
   assign coef_rows[2] = coef_row_bottom;

   // take a window only when the result buffer has a slot for it
   assign out_used = {1'b0, count_ff} + (OUT_CNT_W + 1)'(a_valid_ff)
                   + (OUT_CNT_W + 1)'(b_valid_ff);
   assign q_pop = ~q_empty && (out_used < (OUT_CNT_W + 1)'(OUT_DEPTH));

   // stage A: nine pixel by coefficient products
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int u = 0; u < 3; u++) begin
            prod_in[r*3 + u] = 25'($signed({1'b0, q_head.px[r*3 + u]}))
                             * 25'($signed(coef_rows[r][16*u +: 16]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         a_prod_ff <= prod_in;
         a_col_ff  <= q_head.center_col;
         a_row_ff  <= q_head.center_row;
      end
   end

   // stage B: row sums
   always_ff @(posedge clock) begin
      if (a_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            b_sum_ff[r] <= 27'(a_prod_ff[r*3]) + 27'(a_prod_ff[r*3 + 1])
                         + 27'(a_prod_ff[r*3 + 2]);
         end
         b_col_ff <= a_col_ff;
         b_row_ff <= a_row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= q_pop;
         b_valid_ff <= a_valid_ff;
      end
   end

   // final sum into the result buffer
   always_comb begin
      result.filtered_value = 28'(b_sum_ff[0]) + 28'(b_sum_ff[1]) + 28'(b_sum_ff[2]);
      result.center_col     = b_col_ff;
      result.center_row     = b_row_ff;
   end

   assign do_pop    = rsp_pop & (count_ff != '0);
   assign rsp_empty = (count_ff == '0);
   assign rsp_data  = out_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (b_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + OUT_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + OUT_PTR_W'(1);
         end
         count_ff <= count_ff + OUT_CNT_W'(b_valid_ff) - OUT_CNT_W'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (b_valid_ff) begin
         out_ff[wr_ptr_ff] <= result;
      end
   end

endmodule

[rtl/conv2d_3x3_stream_top.sv]
// Path: pixel to rsp_data via stage 1, window queue, stages A and B, result buffer.
// Throughput: one pixel per clock; a pixel enters each cycle while the 4-entry window
// queue and the 4-entry result buffer have room, set by the back end's 2-stage MAC.
// Reset: synchronous, active high; clears counters, queues and the window, loads the
// CSRs with their defaults. Line buffers are not cleared and need no clearing pass.
module conv2d_3x3_stream_top #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  c2d_pkg::req_type       req_data,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output c2d_pkg::rsp_type       rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  c2d_pkg::csr_index_type csr_index,
   input  logic [47:0]            csr_data
);
   import c2d_pkg::*;

   logic [12:0] image_width_ff;
   logic [47:0] coef_top_ff, coef_mid_ff, coef_bottom_ff;

   logic                q_push, q_pop, q_empty;
   win_type             q_data, q_head;
   logic [Q_CNT_W-1:0]  q_count;

   // CSR writes, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= WIDTH_RESET;
         coef_top_ff    <= COEF_TOP_RESET;
         coef_mid_ff    <= COEF_MID_RESET;
         coef_bottom_ff <= COEF_BOTTOM_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               image_width_ff <= csr_data[12:0];
            end
            CSR_COEF_TOP: begin
               coef_top_ff <= csr_data;
            end
            CSR_COEF_MID: begin
               coef_mid_ff <= csr_data;
            end
            CSR_COEF_BOTTOM: begin
               coef_bottom_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // front end: positions, line buffers, window
   c2d_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .image_width (image_width_ff),
      .q_count     (q_count),
      .q_push      (q_push),
      .q_data      (q_data)
   );

   // window queue between front and back
   c2d_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head),
      .count     (q_count)
   );

   // back end: multiply-accumulate and result buffer
   c2d_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .coef_row_top    (coef_top_ff),
      .coef_row_mid    (coef_mid_ff),
      .coef_row_bottom (coef_bottom_ff),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_data        (rsp_data)
   );

endmodule
